FILE: src/pipt_pkg.sv
// shared types and codes for the point-in-polyhedron plane test
package pipt_pkg;

  localparam int FIELD_W  = 16;
  localparam int STORED_W = 11;
  localparam int OP_W     = 2;

  // item operation codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [FIELD_W-1:0] first_x;
    logic signed [FIELD_W-1:0] first_y;
    logic signed [FIELD_W-1:0] first_z;
    logic signed [FIELD_W-1:0] second_x;
    logic signed [FIELD_W-1:0] second_y;
    logic signed [FIELD_W-1:0] second_z;
    logic signed [FIELD_W-1:0] third_x;
    logic signed [FIELD_W-1:0] third_y;
    logic signed [FIELD_W-1:0] third_z;
  } in_item_t;

  typedef struct packed {
    logic                answer_valid;
    logic                inside_res;
    logic                load_dropped;
    logic [STORED_W-1:0] faces_stored;
  } out_item_t;

  // read data qualifier travelling with the plane memory output
  typedef struct packed {
    logic valid;
    logic last;
  } rd_ctl_t;

  // evaluation status back to the controller
  typedef struct packed {
    logic done;
    logic outside;
  } eval_res_t;

endpackage

FILE: src/pipt_plane_mem.sv
// plane table memory, one write port and one registered read port
module pipt_plane_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 158
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/pipt_plane_calc.sv
// plane coefficient pipeline: cross product of edges and offset from first vertex
module pipt_plane_calc #(
  parameter  int COORD_BITS = 16,
  localparam int PLW        = 9 * COORD_BITS + 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  pipt_pkg::in_item_t item,
  output logic               done,
  output logic [PLW-1:0]     plane
);
  import pipt_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int DFW = C + 1;
  localparam int PRW = 2 * C + 2;
  localparam int ABW = 2 * C + 3;
  localparam int TW  = 3 * C + 3;
  localparam int DDW = 3 * C + 5;

  logic signed [C-1:0]   x1, y1, z1, x2, y2, z2, x3, y3, z3;
  logic signed [C-1:0]   x1_r, y1_r, z1_r;
  logic signed [DFW-1:0] ux_nxt, uy_nxt, uz_nxt, vx_nxt, vy_nxt, vz_nxt;
  logic signed [DFW-1:0] ux_r, uy_r, uz_r, vx_r, vy_r, vz_r;
  logic signed [PRW-1:0] pa0_nxt, pa1_nxt, pb0_nxt, pb1_nxt, pc0_nxt, pc1_nxt;
  logic signed [PRW-1:0] pa0_r, pa1_r, pb0_r, pb1_r, pc0_r, pc1_r;
  logic signed [ABW-1:0] a_nxt, b_nxt, c_nxt;
  logic signed [ABW-1:0] a_r, b_r, c_r;
  logic signed [TW-1:0]  ax_nxt, by_nxt, cz_nxt;
  logic signed [TW-1:0]  ax_r, by_r, cz_r;
  logic signed [DDW-1:0] d_nxt, d_r;
  logic [4:0]            v_r, v_nxt;

  // coordinates from their low bits
  always_comb begin
    x1 = item.first_x[C-1:0];
    y1 = item.first_y[C-1:0];
    z1 = item.first_z[C-1:0];
    x2 = item.second_x[C-1:0];
    y2 = item.second_y[C-1:0];
    z2 = item.second_z[C-1:0];
    x3 = item.third_x[C-1:0];
    y3 = item.third_y[C-1:0];
    z3 = item.third_z[C-1:0];
  end

  // stage 0: edge vectors
  always_comb begin
    ux_nxt = DFW'(x2) - DFW'(x1);
    uy_nxt = DFW'(y2) - DFW'(y1);
    uz_nxt = DFW'(z2) - DFW'(z1);
    vx_nxt = DFW'(x3) - DFW'(x1);
    vy_nxt = DFW'(y3) - DFW'(y1);
    vz_nxt = DFW'(z3) - DFW'(z1);
  end

  // stage 1: cross product terms
  always_comb begin
    pa0_nxt = PRW'(uy_r) * PRW'(vz_r);
    pa1_nxt = PRW'(uz_r) * PRW'(vy_r);
    pb0_nxt = PRW'(uz_r) * PRW'(vx_r);
    pb1_nxt = PRW'(ux_r) * PRW'(vz_r);
    pc0_nxt = PRW'(ux_r) * PRW'(vy_r);
    pc1_nxt = PRW'(uy_r) * PRW'(vx_r);
  end

  // stage 2: normal vector
  always_comb begin
    a_nxt = ABW'(pa0_r) - ABW'(pa1_r);
    b_nxt = ABW'(pb0_r) - ABW'(pb1_r);
    c_nxt = ABW'(pc0_r) - ABW'(pc1_r);
  end

  // stage 3: normal times first vertex
  always_comb begin
    ax_nxt = TW'(a_r) * TW'(x1_r);
    by_nxt = TW'(b_r) * TW'(y1_r);
    cz_nxt = TW'(c_r) * TW'(z1_r);
  end

  // stage 4: plane offset
  always_comb begin
    d_nxt = -(DDW'(ax_r) + DDW'(by_r) + DDW'(cz_r));
    v_nxt = {v_r[3:0], start};
  end

  // datapath registers, the item is held for the whole load
  always_ff @(posedge clk) begin
    x1_r  <= x1;
    y1_r  <= y1;
    z1_r  <= z1;
    ux_r  <= ux_nxt;
    uy_r  <= uy_nxt;
    uz_r  <= uz_nxt;
    vx_r  <= vx_nxt;
    vy_r  <= vy_nxt;
    vz_r  <= vz_nxt;
    pa0_r <= pa0_nxt;
    pa1_r <= pa1_nxt;
    pb0_r <= pb0_nxt;
    pb1_r <= pb1_nxt;
    pc0_r <= pc0_nxt;
    pc1_r <= pc1_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    ax_r  <= ax_nxt;
    by_r  <= by_nxt;
    cz_r  <= cz_nxt;
    d_r   <= d_nxt;
  end

  // stage valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign done  = v_r[4];
  assign plane = {a_r, b_r, c_r, d_r};

endmodule

FILE: src/pipt_eval.sv
// plane value pipeline: one stored plane per cycle against the query point
module pipt_eval #(
  parameter  int COORD_BITS = 16,
  localparam int PLW        = 9 * COORD_BITS + 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  pipt_pkg::in_item_t  item,
  input  logic                outside_sign,
  input  pipt_pkg::rd_ctl_t   rd_ctl,
  input  logic [PLW-1:0]      plane,
  output pipt_pkg::eval_res_t res
);
  import pipt_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int ABW = 2 * C + 3;
  localparam int TW  = 3 * C + 3;
  localparam int DDW = 3 * C + 5;
  localparam int EVW = 3 * C + 7;

  logic signed [C-1:0]   px, py, pz;
  logic signed [ABW-1:0] pl_a, pl_b, pl_c;
  logic signed [DDW-1:0] pl_d;
  logic signed [TW-1:0]  ax_nxt, by_nxt, cz_nxt, ax_r, by_r, cz_r;
  logic signed [DDW-1:0] d1_r;
  logic signed [EVW-1:0] s0_nxt, s1_nxt, s0_r, s1_r, val;
  rd_ctl_t               ctl1_r, ctl2_r;
  logic                  hit;
  logic                  outside_r, outside_nxt;
  logic                  done_r, done_nxt;

  // split the memory word and take the point
  always_comb begin
    pl_a = plane[PLW-1 -: ABW];
    pl_b = plane[PLW-1-ABW -: ABW];
    pl_c = plane[DDW+ABW-1 -: ABW];
    pl_d = plane[DDW-1:0];
    px   = item.first_x[C-1:0];
    py   = item.first_y[C-1:0];
    pz   = item.first_z[C-1:0];
  end

  // stage 1: coefficient products
  always_comb begin
    ax_nxt = TW'(pl_a) * TW'(px);
    by_nxt = TW'(pl_b) * TW'(py);
    cz_nxt = TW'(pl_c) * TW'(pz);
  end

  // stage 2: partial sums
  always_comb begin
    s0_nxt = EVW'(ax_r) + EVW'(by_r);
    s1_nxt = EVW'(cz_r) + EVW'(d1_r);
  end

  // stage 3: plane value sign against the selected outside side
  always_comb begin
    val = s0_r + s1_r;
    hit = outside_sign ? (!val[EVW-1] && (val != '0)) : val[EVW-1];
    outside_nxt = outside_r;
    done_nxt    = 1'b0;
    if (start) begin
      outside_nxt = 1'b0;
    end else if (ctl2_r.valid) begin
      outside_nxt = outside_r | hit;
      done_nxt    = ctl2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= ax_nxt;
    by_r <= by_nxt;
    cz_r <= cz_nxt;
    d1_r <= pl_d;
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

  // qualifiers and the running verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r    <= '0;
      ctl2_r    <= '0;
      outside_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      ctl1_r    <= rd_ctl;
      ctl2_r    <= ctl1_r;
      outside_r <= outside_nxt;
      done_r    <= done_nxt;
    end
  end

  assign res.done    = done_r;
  assign res.outside = outside_r;

endmodule

FILE: src/point_in_polyhedron_plane_test.sv
// top level: controller, plane table, load and query pipelines, result register
// load: the plane passes the five-stage plane pipeline, is written to the table, then the result is registered
// query over n stored planes: one plane memory read per cycle, then the plane value pipeline drains
// query on an empty table, clear, dropped load, unused op: straight from idle to the result register
// one item at a time; the next item is taken while the last result waits
// synchronous active-low reset empties the table and sets outside_sign to 1
module point_in_polyhedron_plane_test #(
  parameter int MAX_FACES  = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pipt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pipt_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import pipt_pkg::*;

  localparam int CW   = $clog2(MAX_FACES + 1);
  localparam int AW   = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int PLW  = 9 * COORD_BITS + 14;
  localparam int ST_W = 3;

  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_LOAD  = 3'd1;
  localparam logic [ST_W-1:0] ST_QUERY = 3'd2;
  localparam logic [ST_W-1:0] ST_DRAIN = 3'd3;
  localparam logic [ST_W-1:0] ST_RESP  = 3'd4;

  logic [ST_W-1:0]        state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          idx_r, idx_nxt, idx_inc;
  in_item_t               item_r, item_nxt;
  logic                   start_r, start_nxt;
  rd_ctl_t                rd_ctl_r, rd_ctl_nxt;
  logic                   sign_r, sign_nxt;
  logic                   res_answer_r, res_answer_nxt;
  logic                   res_inside_r, res_inside_nxt;
  logic                   res_dropped_r, res_dropped_nxt;
  out_item_t              out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CW+STORED_W-1:0] count_ext;
  logic                   in_acc, qry_start;
  logic                   mem_we, mem_re, issue_last;
  logic                   calc_done;
  logic [PLW-1:0]         calc_plane, mem_rdata;
  eval_res_t              eval_res;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign qry_start = in_acc && (in_data.op == OP_QUERY);
  assign cfg_ready = 1'b1;
  assign idx_inc   = idx_r + CW'(1);
  assign count_ext = {{STORED_W{1'b0}}, count_r};

  // controller
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    item_nxt        = item_r;
    start_nxt       = 1'b0;
    res_answer_nxt  = res_answer_r;
    res_inside_nxt  = res_inside_r;
    res_dropped_nxt = res_dropped_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    issue_last      = 1'b0;
    sign_nxt        = cfg_valid ? cfg_data : sign_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          item_nxt        = in_data;
          res_answer_nxt  = 1'b0;
          res_inside_nxt  = 1'b0;
          res_dropped_nxt = 1'b0;
          case (in_data.op)
            OP_LOAD: begin
              if (count_r == CW'(MAX_FACES)) begin
                res_dropped_nxt = 1'b1;
                state_nxt       = ST_RESP;
              end else begin
                start_nxt = 1'b1;
                state_nxt = ST_LOAD;
              end
            end
            OP_QUERY: begin
              res_answer_nxt = 1'b1;
              idx_nxt        = '0;
              if (count_r == '0) begin
                res_inside_nxt = 1'b1;
                state_nxt      = ST_RESP;
              end else begin
                state_nxt = ST_QUERY;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = ST_RESP;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      // append the finished plane
      ST_LOAD: begin
        if (calc_done) begin
          mem_we    = 1'b1;
          count_nxt = count_r + CW'(1);
          state_nxt = ST_RESP;
        end
      end
      // walk the table, one read per cycle
      ST_QUERY: begin
        mem_re     = 1'b1;
        issue_last = (idx_inc == count_r);
        idx_nxt    = idx_inc;
        if (issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (eval_res.done) begin
          res_inside_nxt = !eval_res.outside;
          state_nxt      = ST_RESP;
        end
      end
      // hand the result to the output register once it is free
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.answer_valid = res_answer_r;
          out_nxt.inside_res   = res_inside_r;
          out_nxt.load_dropped = res_dropped_r;
          out_nxt.faces_stored = count_ext[STORED_W-1:0];
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    rd_ctl_nxt.valid = mem_re;
    rd_ctl_nxt.last  = issue_last;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      start_r     <= 1'b0;
      rd_ctl_r    <= '0;
      sign_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      start_r     <= start_nxt;
      rd_ctl_r    <= rd_ctl_nxt;
      sign_r      <= sign_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r        <= item_nxt;
    res_answer_r  <= res_answer_nxt;
    res_inside_r  <= res_inside_nxt;
    res_dropped_r <= res_dropped_nxt;
    out_r         <= out_nxt;
  end

  pipt_plane_calc #(
    .COORD_BITS (COORD_BITS)
  ) u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .item  (item_r),
    .done  (calc_done),
    .plane (calc_plane)
  );

  pipt_plane_mem #(
    .DEPTH (MAX_FACES),
    .AW    (AW),
    .DW    (PLW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (count_r[AW-1:0]),
    .wdata (calc_plane),
    .re    (mem_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  pipt_eval #(
    .COORD_BITS (COORD_BITS)
  ) u_eval (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (qry_start),
    .item         (item_r),
    .outside_sign (sign_r),
    .rd_ctl       (rd_ctl_r),
    .plane        (mem_rdata),
    .res          (eval_res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: src/pipt_checker.sv
// port-level checks on the plane test block and their binding
module pipt_checker #(
  parameter int MAX_FACES = 1024
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input pipt_pkg::out_item_t out_data
);
  import pipt_pkg::*;

  // a waiting result holds still
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // only a query answer can say inside
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.inside_res |-> out_data.answer_valid)
    else $error("inside reported without a query answer");

  // a dropped load means a full table and is not a query answer
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.load_dropped |->
      !out_data.answer_valid && (out_data.faces_stored == STORED_W'(MAX_FACES)))
    else $error("dropped load with table not full");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

endmodule

bind point_in_polyhedron_plane_test pipt_checker #(
  .MAX_FACES (MAX_FACES)
) u_pipt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: dv/testbench.sv
// self-checking testbench for the point-in-polyhedron plane test block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pipt_pkg::*;

  localparam int MAX_FACES    = 1024;
  localparam int COORD_BITS   = 16;
  localparam int RANDOM_ITEMS = 580;
  localparam int STALL_LIMIT  = 20000;
  localparam int IDLE_PCT     = 17;
  localparam int TAIL_CYCLES  = 20;
  localparam int PRINT_CAP    = 60;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  point_in_polyhedron_plane_test #(
    .MAX_FACES (MAX_FACES),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // shadow copy of the plane table and the sign register
  longint      plane_a [MAX_FACES];
  longint      plane_b [MAX_FACES];
  longint      plane_c [MAX_FACES];
  longint      plane_d [MAX_FACES];
  int unsigned planes_held      = 0;
  bit          outside_positive = 1'b1;

  out_item_t   expected_verdicts[$];
  bit          no_idle = 1'b0;
  int unsigned items_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned mismatch_lines = 0;
  int unsigned results_checked = 0;
  int unsigned n_loads = 0, n_dropped = 0, n_queries = 0, n_clears = 0, n_unused = 0;
  int unsigned n_sign_writes = 0;

  // coordinate from its low COORD_BITS bits, two's complement
  function automatic longint coord(logic [FIELD_W-1:0] raw);
    return longint'($signed(raw[COORD_BITS-1:0]));
  endfunction

  // plane of a triangle: normal by cross product of the edges, offset from the first vertex
  function automatic void plane_of(input in_item_t f, output longint a, b, c, d);
    longint x1, y1, z1, ux, uy, uz, vx, vy, vz;
    x1 = coord(f.first_x);
    y1 = coord(f.first_y);
    z1 = coord(f.first_z);
    ux = coord(f.second_x) - x1;
    uy = coord(f.second_y) - y1;
    uz = coord(f.second_z) - z1;
    vx = coord(f.third_x) - x1;
    vy = coord(f.third_y) - y1;
    vz = coord(f.third_z) - z1;
    a = uy * vz - uz * vy;
    b = uz * vx - ux * vz;
    c = ux * vy - uy * vx;
    d = -(a * x1 + b * y1 + c * z1);
  endfunction

  function automatic longint plane_value(input longint a, b, c, d, x, y, z);
    return a * x + b * y + c * z + d;
  endfunction

  // expected result of one accepted item, updating the shadow table
  function automatic out_item_t predict_verdict(in_item_t it);
    out_item_t   r;
    longint      a, b, c, d, x, y, z, v;
    bit          outside;
    int unsigned i;
    r = '0;
    outside = 1'b0;
    case (it.op)
      OP_LOAD: begin
        if (planes_held >= MAX_FACES) begin
          r.load_dropped = 1'b1;
        end else begin
          plane_of(it, a, b, c, d);
          plane_a[planes_held] = a;
          plane_b[planes_held] = b;
          plane_c[planes_held] = c;
          plane_d[planes_held] = d;
          planes_held++;
        end
      end
      OP_QUERY: begin
        x = coord(it.first_x);
        y = coord(it.first_y);
        z = coord(it.first_z);
        for (i = 0; i < planes_held; i++) begin
          v = plane_value(plane_a[i], plane_b[i], plane_c[i], plane_d[i], x, y, z);
          if (outside_positive ? (v > 0) : (v < 0)) outside = 1'b1;
        end
        r.answer_valid = 1'b1;
        r.inside_res   = !outside;
      end
      OP_CLEAR: begin
        planes_held = 0;
      end
      default: begin
      end
    endcase
    r.faces_stored = planes_held[STORED_W-1:0];
    return r;
  endfunction

  // item with random bits in every field and the given op
  function automatic in_item_t random_item(logic [OP_W-1:0] op);
    logic [159:0] bits;
    in_item_t     it;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = bits[$bits(in_item_t)-1:0];
    it.op = op;
    return it;
  endfunction

  // query point; the unused vertex fields carry random bits
  function automatic in_item_t make_query(longint x, longint y, longint z);
    in_item_t it;
    it = random_item(OP_QUERY);
    it.first_x = x[FIELD_W-1:0];
    it.first_y = y[FIELD_W-1:0];
    it.first_z = z[FIELD_W-1:0];
    return it;
  endfunction

  function automatic in_item_t make_load(longint x1, y1, z1, x2, y2, z2, x3, y3, z3);
    in_item_t it;
    it.op       = OP_LOAD;
    it.first_x  = x1[FIELD_W-1:0];
    it.first_y  = y1[FIELD_W-1:0];
    it.first_z  = z1[FIELD_W-1:0];
    it.second_x = x2[FIELD_W-1:0];
    it.second_y = y2[FIELD_W-1:0];
    it.second_z = z2[FIELD_W-1:0];
    it.third_x  = x3[FIELD_W-1:0];
    it.third_y  = y3[FIELD_W-1:0];
    it.third_z  = z3[FIELD_W-1:0];
    return it;
  endfunction

  function automatic longint jitter(int unsigned spread);
    return longint'($urandom_range(2 * spread)) - longint'(spread);
  endfunction

  // swap two vertices where needed so the point lands on the wanted side of the face
  function automatic in_item_t orient_face(in_item_t f, longint px, py, pz, bit point_inside);
    longint             a, b, c, d, v;
    bit                 is_outside;
    logic [FIELD_W-1:0] held;
    plane_of(f, a, b, c, d);
    v = plane_value(a, b, c, d, px, py, pz);
    is_outside = outside_positive ? (v > 0) : (v < 0);
    if (is_outside == point_inside) begin
      held = f.second_x; f.second_x = f.third_x; f.third_x = held;
      held = f.second_y; f.second_y = f.third_y; f.third_y = held;
      held = f.second_z; f.second_z = f.third_z; f.third_z = held;
    end
    return f;
  endfunction

  // present one item, hold it until accepted, then record its expected result
  task automatic send_item(input in_item_t it);
    out_item_t predicted;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_verdict(it);
    expected_verdicts.insert(expected_verdicts.size(), predicted);
    items_accepted++;
    case (it.op)
      OP_LOAD: begin
        n_loads++;
        if (predicted.load_dropped) n_dropped++;
      end
      OP_QUERY: begin
        n_queries++;
      end
      OP_CLEAR: begin
        n_clears++;
      end
      default: begin
        n_unused++;
      end
    endcase
  endtask

  // stop sending and wait until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_outside_sign(input bit value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    outside_positive = value;
    n_sign_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result receiver with random stalls
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic void note_mismatch(string field, logic [STORED_W-1:0] want,
                                        logic [STORED_W-1:0] got);
    if (mismatch_lines < PRINT_CAP) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
    mismatch_lines++;
  endfunction

  // compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    out_item_t wanted;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatch_lines < PRINT_CAP) begin
          $display("%0t: result with none expected, expected nothing, got %p", $time, out_data);
        end
        mismatch_lines++;
      end else begin
        wanted = expected_verdicts.pop_front();
        results_checked++;
        if (out_data !== wanted) begin
          mismatches++;
          if (out_data.answer_valid !== wanted.answer_valid)
            note_mismatch("answer_valid", wanted.answer_valid, out_data.answer_valid);
          if (out_data.inside_res !== wanted.inside_res)
            note_mismatch("inside_res", wanted.inside_res, out_data.inside_res);
          if (out_data.load_dropped !== wanted.load_dropped)
            note_mismatch("load_dropped", wanted.load_dropped, out_data.load_dropped);
          if (out_data.faces_stored !== wanted.faces_stored)
            note_mismatch("faces_stored", wanted.faces_stored, out_data.faces_stored);
        end
      end
    end
  end

  // watchdog on cycles in which no item moves on any channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // empty table queries, unused op and clear
  task automatic test_empty_and_unused_ops();
    send_item(make_query(0, 0, 0));
    send_item(make_query(-32768, 32767, -32768));
    send_item(random_item(OP_UNUSED));
    send_item(random_item(OP_CLEAR));
  endtask

  // coordinate extremes, degenerate triangles, points on a plane
  task automatic test_triangle_extremes();
    send_item(make_load(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768));
    send_item(make_load(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768));
    // coincident and collinear vertices give an all-zero plane
    send_item(make_load(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_item(make_load(0, 0, 0, 1, 1, 1, 2, 2, 2));
    // on the first plane, then a far corner and a point on an edge of the range, then a vertex of the second plane
    send_item(make_query(-32768, -32768, -32768));
    send_item(make_query(32767, 32767, 32767));
    send_item(make_query(-32768, 32767, 0));
    send_item(make_query(32767, -32768, 32767));
    send_item(random_item(OP_UNUSED));
    send_item(random_item(OP_CLEAR));
    send_item(make_query(0, 0, 0));
  endtask

  // same tetrahedron and points under both settings of the sign register
  task automatic test_outside_sign();
    write_outside_sign(1'b0);
    send_item(random_item(OP_CLEAR));
    send_item(orient_face(make_load(0, 0, 0, 1000, 0, 0, 0, 1000, 0), 250, 250, 250, 1'b1));
    send_item(orient_face(make_load(0, 0, 0, 1000, 0, 0, 0, 0, 1000), 250, 250, 250, 1'b1));
    send_item(orient_face(make_load(0, 0, 0, 0, 1000, 0, 0, 0, 1000), 250, 250, 250, 1'b1));
    send_item(orient_face(make_load(1000, 0, 0, 0, 1000, 0, 0, 0, 1000), 250, 250, 250, 1'b1));
    for (int pass = 0; pass < 2; pass++) begin
      send_item(make_query(250, 250, 250));
      send_item(make_query(2000, 2000, 2000));
      send_item(make_query(-1, -1, -1));
      send_item(make_query(0, 0, 500));
      if (pass == 0) write_outside_sign(1'b1);
    end
  endtask

  // fill the table, so only the last plane decides, then loads and other ops on the full table, a clear and a query
  task automatic test_full_table();
    longint   px, py, pz, a, b, c, d;
    in_item_t last_face;
    px = jitter(1000);
    py = jitter(1000);
    pz = jitter(1000);
    send_item(random_item(OP_CLEAR));
    for (int k = 0; k < MAX_FACES - 1; k++) begin
      send_item(orient_face(random_item(OP_LOAD), px, py, pz, 1'b1));
    end
    do begin
      last_face = orient_face(random_item(OP_LOAD), px, py, pz, 1'b0);
      plane_of(last_face, a, b, c, d);
    end while (plane_value(a, b, c, d, px, py, pz) == 0);
    send_item(last_face);
    send_item(make_query(px, py, pz));
    send_item(random_item(OP_LOAD));
    send_item(random_item(OP_LOAD));
    send_item(random_item(OP_UNUSED));
    send_item(random_item(OP_QUERY));
    send_item(random_item(OP_CLEAR));
    send_item(make_query(px, py, pz));
  endtask

  // random convex bodies with queries around them, mixed with noise and pauses
  task automatic test_random_polyhedra();
    int unsigned start, done, pick, spread, n_faces, n_points, sel;
    longint      cx, cy, cz;
    in_item_t    face;
    in_item_t    faces[$];
    start = items_accepted;
    done  = 0;
    while (done < RANDOM_ITEMS) begin
      // one long stretch with neither side idling
      no_idle = (done >= 150 && done < 300);
      pick = $urandom_range(99);
      if (pick < 75) begin
        cx = jitter(20000);
        cy = jitter(20000);
        cz = jitter(20000);
        spread  = ($urandom_range(3) == 0) ? $urandom_range(10000, 2000)
                                           : $urandom_range(2000, 20);
        n_faces = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        if ($urandom_range(99) < 85) send_item(random_item(OP_CLEAR));
        faces.delete();
        for (int k = 0; k < n_faces; k++) begin
          face = make_load(cx + jitter(spread), cy + jitter(spread), cz + jitter(spread),
                           cx + jitter(spread), cy + jitter(spread), cz + jitter(spread),
                           cx + jitter(spread), cy + jitter(spread), cz + jitter(spread));
          face = orient_face(face, cx, cy, cz, 1'b1);
          faces.insert(faces.size(), face);
          send_item(face);
        end
        n_points = $urandom_range(10, 2);
        for (int k = 0; k < n_points; k++) begin
          sel = $urandom_range(3);
          if (sel == 0) begin
            send_item(make_query(cx, cy, cz));
          end else if (sel == 1) begin
            // a vertex lies on its own face
            face = faces[$urandom_range(faces.size() - 1)];
            send_item(make_query(coord(face.first_x), coord(face.first_y),
                                 coord(face.first_z)));
          end else begin
            send_item(make_query(cx + jitter(spread), cy + jitter(spread),
                                 cz + jitter(spread)));
          end
        end
      end else if (pick < 93) begin
        send_item(random_item(OP_W'($urandom_range(3))));
      end else if (pick < 97) begin
        drain_results();
      end else begin
        write_outside_sign(1'($urandom_range(1)));
      end
      done = items_accepted - start;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_and_unused_ops();
    test_triangle_extremes();
    test_outside_sign();
    test_full_table();
    test_random_polyhedra();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d loads (%0d refused by a full table), %0d queries, %0d clears, %0d unused ops",
             n_loads, n_dropped, n_queries, n_clears, n_unused);
    $display("outside_sign written %0d times, %0d results checked, %0d mismatching",
             n_sign_writes, results_checked, mismatches);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
